// ===== hw/rtl/rhc_pkg.sv =====
// Shared types and constants for the RGB to HSL converter.
package rhc_pkg;

  localparam int unsigned DivSteps = 17;

  localparam logic [14:0] HUE_FULL  = 15'd23040;
  localparam logic [14:0] HUE_RED   = 15'd0;
  localparam logic [14:0] HUE_GREEN = 15'd7680;
  localparam logic [14:0] HUE_BLUE  = 15'd15360;

  // One restoring divider: partial remainder, divisor, dividend bits still
  // to shift in (MSB first) and quotient bits gathered so far.
  typedef struct packed {
    logic [7:0]  den;
    logic [7:0]  rem;
    logic [16:0] dvd;
    logic [16:0] quo;
  } div_t;

  // Fields that ride along with the dividers.
  typedef struct packed {
    logic        grey;
    logic        neg;
    logic [14:0] base;
    logic [8:0]  light;
    logic [7:0]  alpha;
  } side_t;

  typedef struct packed {
    div_t  hue;
    div_t  sat;
    side_t side;
  } stage_t;

endpackage

// ===== hw/rtl/rhc_front.sv =====
// Input stage: max/min, sector choice and divider preload.
module rhc_front import rhc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       i_valid,
  output logic       i_ready,
  input  logic [7:0] i_red,
  input  logic [7:0] i_green,
  input  logic [7:0] i_blue,
  input  logic [7:0] i_alpha,
  output logic       o_valid,
  input  logic       o_ready,
  output stage_t     o_data
);

  logic        valid_r;
  stage_t      data_r;
  stage_t      data_nxt;
  logic [7:0]  mx;
  logic [7:0]  mn;
  logic [7:0]  chroma;
  logic [8:0]  light;
  logic [7:0]  diff;
  logic        neg;
  logic [14:0] base;
  logic [19:0] hdvd;
  logic [7:0]  sden;

  assign i_ready = !valid_r || o_ready;
  assign o_valid = valid_r;
  assign o_data  = data_r;

  always_comb begin
    mx = i_red;
    mn = i_red;
    if (i_green > mx) mx = i_green;
    if (i_blue > mx) mx = i_blue;
    if (i_green < mn) mn = i_green;
    if (i_blue < mn) mn = i_blue;
    chroma = mx - mn;
    light  = {1'b0, mx} + {1'b0, mn};

    // Ties go to red, then green, then blue.
    if (mx == i_red) begin
      neg  = i_green < i_blue;
      diff = neg ? (i_blue - i_green) : (i_green - i_blue);
      base = neg ? HUE_FULL : HUE_RED;
    end else if (mx == i_green) begin
      neg  = i_blue < i_red;
      diff = neg ? (i_red - i_blue) : (i_blue - i_red);
      base = HUE_GREEN;
    end else begin
      neg  = i_red < i_green;
      diff = neg ? (i_green - i_red) : (i_red - i_green);
      base = HUE_BLUE;
    end

    // 3840 * diff as a shift and subtract
    hdvd = {diff, 12'd0} - {4'd0, diff, 8'd0};
    sden = light[8] ? 8'(9'd510 - light) : light[7:0];

    data_nxt.hue.den  = chroma;
    data_nxt.hue.rem  = {5'd0, hdvd[19:17]};
    data_nxt.hue.dvd  = hdvd[16:0];
    data_nxt.hue.quo  = '0;
    data_nxt.sat.den  = sden;
    data_nxt.sat.rem  = {1'b0, chroma[7:1]};
    data_nxt.sat.dvd  = {chroma[0], 16'd0};
    data_nxt.sat.quo  = '0;
    data_nxt.side.grey  = (chroma == 8'd0);
    data_nxt.side.neg   = neg;
    data_nxt.side.base  = base;
    data_nxt.side.light = light;
    data_nxt.side.alpha = i_alpha;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (i_ready) begin
      valid_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (i_ready && i_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== hw/rtl/rhc_div_cell.sv =====
// One divider cell: a quotient bit for hue and for saturation per item.
module rhc_div_cell import rhc_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   i_valid,
  output logic   i_ready,
  input  stage_t i_data,
  output logic   o_valid,
  input  logic   o_ready,
  output stage_t o_data
);

  logic   valid_r;
  stage_t data_r;
  stage_t data_nxt;

  function automatic div_t div_step(div_t d);
    logic [8:0] trial;
    logic       fit;
    div_t       n;
    trial = {d.rem, d.dvd[16]};
    fit   = trial >= {1'b0, d.den};
    n     = d;
    n.rem = fit ? 8'(trial - {1'b0, d.den}) : trial[7:0];
    n.dvd = {d.dvd[15:0], 1'b0};
    n.quo = {d.quo[15:0], fit};
    return n;
  endfunction

  assign i_ready = !valid_r || o_ready;
  assign o_valid = valid_r;
  assign o_data  = data_r;

  always_comb begin
    data_nxt      = i_data;
    data_nxt.hue  = div_step(i_data.hue);
    data_nxt.sat  = div_step(i_data.sat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (i_ready) begin
      valid_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (i_ready && i_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== hw/rtl/rhc_finish.sv =====
// Output stage: rounding, hue offset and wrap, saturation clamp.
module rhc_finish import rhc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        i_valid,
  output logic        i_ready,
  input  stage_t      i_data,
  output logic        o_valid,
  input  logic        o_ready,
  output logic [14:0] o_hue,
  output logic [15:0] o_saturation,
  output logic [8:0]  o_lightness,
  output logic [7:0]  o_alpha
);

  logic        valid_r;
  logic [14:0] hue_r;
  logic [15:0] sat_r;
  logic [8:0]  light_r;
  logic [7:0]  alpha_r;
  logic [14:0] hue_nxt;
  logic [15:0] sat_nxt;
  logic [8:0]  hrem2;
  logic [8:0]  hden;
  logic        hup;
  logic [12:0] hq;
  logic [14:0] hsum;
  logic        sup;
  logic [17:0] sq;

  assign i_ready      = !valid_r || o_ready;
  assign o_valid      = valid_r;
  assign o_hue        = hue_r;
  assign o_saturation = sat_r;
  assign o_lightness  = light_r;
  assign o_alpha      = alpha_r;

  always_comb begin
    hrem2 = {i_data.hue.rem, 1'b0};
    hden  = {1'b0, i_data.hue.den};
    // Negative offsets round exact halves towards zero in magnitude.
    hup   = i_data.side.neg ? (hrem2 > hden) : (hrem2 >= hden);
    hq    = {1'b0, i_data.hue.quo[11:0]} + {12'd0, hup};
    hsum  = i_data.side.neg ? (i_data.side.base - {2'd0, hq})
                            : (i_data.side.base + {2'd0, hq});
    if (hsum >= HUE_FULL) hsum = hsum - HUE_FULL;

    sup = {i_data.sat.rem, 1'b0} >= {1'b0, i_data.sat.den};
    sq  = {1'b0, i_data.sat.quo} + {17'd0, sup};

    if (i_data.side.grey) begin
      hue_nxt = '0;
      sat_nxt = '0;
    end else begin
      hue_nxt = hsum;
      sat_nxt = (sq[17:16] != 2'd0) ? 16'hFFFF : sq[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (i_ready) begin
      valid_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (i_ready && i_valid) begin
      hue_r   <= hue_nxt;
      sat_r   <= sat_nxt;
      light_r <= i_data.side.light;
      alpha_r <= i_data.side.alpha;
    end
  end

endmodule

// ===== hw/rtl/rgb_to_hsl_converter_unit.sv =====
// Top level of the RGB to HSL converter: front stage, divider chain, output stage.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_ready  in_red, in_green, in_blue, in_alpha
//   out_     output     out_valid/out_ready  out_hue, out_saturation,
//                                            out_lightness, out_alpha_out
//
// One item per cycle when out_ready stays high; each item passes through
// the front stage, 17 divider cells and the output stage.
// The 17 quotient bits of the saturation divide set the chain length.
// Reset empties every stage; stalls hold an item in place while empty
// stages further down still take items, so bubbles close up.
module rgb_to_hsl_converter_unit import rhc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_alpha,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [14:0] out_hue,
  output logic [15:0] out_saturation,
  output logic [8:0]  out_lightness,
  output logic [7:0]  out_alpha_out
);

  stage_t st    [DivSteps+1];
  logic   st_vld[DivSteps+1];
  logic   st_rdy[DivSteps+1];

  rhc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (in_valid),
    .i_ready (in_ready),
    .i_red   (in_red),
    .i_green (in_green),
    .i_blue  (in_blue),
    .i_alpha (in_alpha),
    .o_valid (st_vld[0]),
    .o_ready (st_rdy[0]),
    .o_data  (st[0])
  );

  for (genvar i = 0; i < DivSteps; i++) begin : g_cell
    rhc_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .i_valid (st_vld[i]),
      .i_ready (st_rdy[i]),
      .i_data  (st[i]),
      .o_valid (st_vld[i+1]),
      .o_ready (st_rdy[i+1]),
      .o_data  (st[i+1])
    );
  end

  rhc_finish u_finish (
    .clk          (clk),
    .rst_n        (rst_n),
    .i_valid      (st_vld[DivSteps]),
    .i_ready      (st_rdy[DivSteps]),
    .i_data       (st[DivSteps]),
    .o_valid      (out_valid),
    .o_ready      (out_ready),
    .o_hue        (out_hue),
    .o_saturation (out_saturation),
    .o_lightness  (out_lightness),
    .o_alpha      (out_alpha_out)
  );

endmodule

// ===== hw/rtl/rhc_checker.sv =====
// Port-level checks for the RGB to HSL converter, bound to the top level.
module rhc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [14:0] out_hue,
  input logic [15:0] out_saturation,
  input logic [8:0]  out_lightness,
  input logic [7:0]  out_alpha_out
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hue) &&
      $stable(out_saturation) && $stable(out_lightness) && $stable(out_alpha_out))
    else $error("result item changed while stalled");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hue < 15'd23040)
    else $error("hue out of range");

  a_light_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_lightness <= 9'd510)
    else $error("lightness out of range");

  a_hue_needs_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hue != 15'd0 |-> out_saturation != 16'd0)
    else $error("coloured item with zero saturation");

  a_black_white: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_lightness == 9'd0 || out_lightness == 9'd510)
      |-> out_saturation == 16'd0 && out_hue == 15'd0)
    else $error("black or white item with colour");

endmodule

bind rgb_to_hsl_converter_unit rhc_checker u_rhc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_hue        (out_hue),
  .out_saturation (out_saturation),
  .out_lightness  (out_lightness),
  .out_alpha_out  (out_alpha_out)
);
